// ===== hdl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Types, widths and helper functions for the matrix-to-quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;

   // radicand: at most about 3*2^15 + 2^14, fits 19 bits unsigned
   localparam int RAD_WIDTH  = DATA_WIDTH + 3;
   // shifted radicand fed to the root, padded at the top to an even bit count
   localparam int SQ_BITS    = RAD_WIDTH + FRAC_BITS;
   localparam int ROOT_WIDTH = (SQ_BITS + 1) / 2;
   localparam int SQIN_WIDTH = 2 * ROOT_WIDTH;
   // reciprocal numerator 2^(2*FRAC_BITS-1)
   localparam int NUM_WIDTH  = 2 * FRAC_BITS;
   localparam int RCP_WIDTH  = NUM_WIDTH;
   // differences and sums of two elements
   localparam int DIFF_WIDTH = DATA_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + RCP_WIDTH + 1;

   localparam int SQ_STEPS   = ROOT_WIDTH;
   localparam int DIV_STEPS  = NUM_WIDTH;

   typedef enum logic [1:0] {
      PATH_TRACE = 2'd0,
      PATH_X     = 2'd1,
      PATH_Y     = 2'd2,
      PATH_Z     = 2'd3
   } path_type;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      data_type m00, m01, m02, m10, m11, m12, m20, m21, m22;
   } matrix_type;

   typedef struct packed {
      data_type quat_w, quat_x, quat_y, quat_z;
      path_type path_taken;
   } quat_type;

   // floor(a*r / 2^FRAC_BITS) saturated to the output range
   function automatic data_type mul_sat(input logic signed [DIFF_WIDTH-1:0] a,
                                        input logic [RCP_WIDTH-1:0] r);
      logic signed [PROD_WIDTH-1:0] p;
      logic signed [PROD_WIDTH-1:0] q;
      logic signed [PROD_WIDTH-1:0] hi;
      logic signed [PROD_WIDTH-1:0] lo;
      begin
         p  = PROD_WIDTH'(a) * $signed({1'b0, r});
         q  = p >>> FRAC_BITS;
         hi = PROD_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
         lo = -hi - PROD_WIDTH'(1);
         if (q > hi) mul_sat = data_type'(hi);
         else if (q < lo) mul_sat = data_type'(lo);
         else mul_sat = data_type'(q);
      end
   endfunction

endpackage

// ===== hdl/rmq_stream_if.sv =====
// ----------------------------------------------------------------------------
// rmq_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface rmq_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/rmq_pipe.sv =====
// ----------------------------------------------------------------------------
// rmq_pipe
// Pipelined conversion: select, root one bit per stage, reciprocal one bit
// per stage, product and saturate.
// ----------------------------------------------------------------------------
module rmq_pipe
   import rmq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       in_valid,
   input  matrix_type in_data,
   output logic       out_valid,
   output quat_type   out_data
);

   localparam int NSTG = 1 + SQ_STEPS + DIV_STEPS;

   // per-item context carried along
   typedef struct packed {
      path_type                      path;
      logic signed [DIFF_WIDTH-1:0]  a0, a1, a2;
   } ctx_type;

   // ---------------- stage 0: path select and radicand
   logic signed [DATA_WIDTH+1:0] trace;
   logic signed [RAD_WIDTH-1:0]  rad;
   ctx_type                      ctx0_in;
   logic signed [DATA_WIDTH-1:0] d0, d1, d2;

   always_comb begin
      d0 = in_data.m00; d1 = in_data.m11; d2 = in_data.m22;
      trace = (DATA_WIDTH+2)'(d0) + (DATA_WIDTH+2)'(d1) + (DATA_WIDTH+2)'(d2);
      if (trace > 0) begin
         ctx0_in.path = PATH_TRACE;
         rad = RAD_WIDTH'(trace) + RAD_WIDTH'(1 << FRAC_BITS);
         ctx0_in.a0 = DIFF_WIDTH'(in_data.m21) - DIFF_WIDTH'(in_data.m12);
         ctx0_in.a1 = DIFF_WIDTH'(in_data.m02) - DIFF_WIDTH'(in_data.m20);
         ctx0_in.a2 = DIFF_WIDTH'(in_data.m10) - DIFF_WIDTH'(in_data.m01);
      end else if (d1 > d0 && !(d2 > d1)) begin
         // y largest: j = z, k = x
         ctx0_in.path = PATH_Y;
         rad = RAD_WIDTH'(d1) - RAD_WIDTH'(d2) - RAD_WIDTH'(d0)
               + RAD_WIDTH'(1 << FRAC_BITS);
         ctx0_in.a0 = DIFF_WIDTH'(in_data.m02) - DIFF_WIDTH'(in_data.m20);
         ctx0_in.a1 = DIFF_WIDTH'(in_data.m21) + DIFF_WIDTH'(in_data.m12);
         ctx0_in.a2 = DIFF_WIDTH'(in_data.m01) + DIFF_WIDTH'(in_data.m10);
      end else if ((d1 > d0 && d2 > d1) || (!(d1 > d0) && d2 > d0)) begin
         // z largest: j = x, k = y
         ctx0_in.path = PATH_Z;
         rad = RAD_WIDTH'(d2) - RAD_WIDTH'(d0) - RAD_WIDTH'(d1)
               + RAD_WIDTH'(1 << FRAC_BITS);
         ctx0_in.a0 = DIFF_WIDTH'(in_data.m10) - DIFF_WIDTH'(in_data.m01);
         ctx0_in.a1 = DIFF_WIDTH'(in_data.m02) + DIFF_WIDTH'(in_data.m20);
         ctx0_in.a2 = DIFF_WIDTH'(in_data.m12) + DIFF_WIDTH'(in_data.m21);
      end else begin
         // x largest: j = y, k = z
         ctx0_in.path = PATH_X;
         rad = RAD_WIDTH'(d0) - RAD_WIDTH'(d1) - RAD_WIDTH'(d2)
               + RAD_WIDTH'(1 << FRAC_BITS);
         ctx0_in.a0 = DIFF_WIDTH'(in_data.m21) - DIFF_WIDTH'(in_data.m12);
         ctx0_in.a1 = DIFF_WIDTH'(in_data.m10) + DIFF_WIDTH'(in_data.m01);
         ctx0_in.a2 = DIFF_WIDTH'(in_data.m20) + DIFF_WIDTH'(in_data.m02);
      end
   end

   // ---------------- pipeline registers
   logic                      vld_ff [NSTG];
   ctx_type                   ctx_ff [NSTG];
   logic [SQIN_WIDTH-1:0]     rem_ff [1+SQ_STEPS];   // root remainder
   logic [SQIN_WIDTH-1:0]     val_ff [1+SQ_STEPS];   // shifted radicand
   logic [ROOT_WIDTH-1:0]     root_ff [NSTG];
   logic [NUM_WIDTH:0]        drem_ff [DIV_STEPS+1];
   logic [RCP_WIDTH-1:0]      quo_ff  [DIV_STEPS+1];
   quat_type                  res_ff;

   // stage 0 register
   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else if (advance) vld_ff[0] <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         ctx_ff[0]  <= ctx0_in;
         // radicand never negative for integer inputs; clamp anyway
         val_ff[0]  <= rad[RAD_WIDTH-1] ? '0
                       : SQIN_WIDTH'({rad[RAD_WIDTH-2:0], {FRAC_BITS{1'b0}}});
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         drem_ff[0] <= '0;
         quo_ff[0]  <= '0;
      end
   end

   // ---------------- root stages: one result bit per stage
   for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
      logic [SQIN_WIDTH-1:0] rem_in;
      logic [SQIN_WIDTH-1:0] trial;
      logic [ROOT_WIDTH-1:0] root_in;
      always_comb begin
         rem_in = SQIN_WIDTH'({rem_ff[g], val_ff[g][SQIN_WIDTH-1 -: 2]});
         trial  = SQIN_WIDTH'({root_ff[g], 2'b01});
         if (rem_in >= trial) begin
            rem_in  = rem_in - trial;
            root_in = ROOT_WIDTH'({root_ff[g], 1'b1});
         end else begin
            root_in = ROOT_WIDTH'({root_ff[g], 1'b0});
         end
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[g+1] <= 1'b0;
         else if (advance) vld_ff[g+1] <= vld_ff[g];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            ctx_ff[g+1]  <= ctx_ff[g];
            rem_ff[g+1]  <= rem_in;
            val_ff[g+1]  <= val_ff[g] << 2;
            root_ff[g+1] <= root_in;
         end
      end
   end

   // ---------------- reciprocal stages: restoring divide, one bit per stage
   localparam logic [NUM_WIDTH-1:0] NUMER = NUM_WIDTH'(1) << (NUM_WIDTH - 1);
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_dv
      localparam int S = SQ_STEPS + g;
      logic [NUM_WIDTH:0] sh;
      logic [NUM_WIDTH:0] nxt;
      logic               bit_q;
      always_comb begin
         sh    = {drem_ff[g][NUM_WIDTH-1:0], NUMER[NUM_WIDTH-1-g]};
         bit_q = (root_ff[S] != '0) && (sh >= (NUM_WIDTH+1)'(root_ff[S]));
         nxt   = bit_q ? sh - (NUM_WIDTH+1)'(root_ff[S]) : sh;
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[S+1] <= 1'b0;
         else if (advance) vld_ff[S+1] <= vld_ff[S];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            ctx_ff[S+1]  <= ctx_ff[S];
            root_ff[S+1] <= root_ff[S];
            drem_ff[g+1] <= nxt;
            quo_ff[g+1]  <= RCP_WIDTH'({quo_ff[g], bit_q});
         end
      end
   end

   // ---------------- product, saturate and place
   localparam int L = NSTG - 1;
   data_type half, p0, p1, p2;
   quat_type res_in;
   always_comb begin
      half = data_type'(root_ff[L] >> 1);
      p0 = mul_sat(ctx_ff[L].a0, quo_ff[DIV_STEPS]);
      p1 = mul_sat(ctx_ff[L].a1, quo_ff[DIV_STEPS]);
      p2 = mul_sat(ctx_ff[L].a2, quo_ff[DIV_STEPS]);
      res_in.path_taken = ctx_ff[L].path;
      unique case (ctx_ff[L].path)
         PATH_TRACE: begin
            res_in.quat_w = half; res_in.quat_x = p0;
            res_in.quat_y = p1;   res_in.quat_z = p2;
         end
         PATH_X: begin
            res_in.quat_w = p0; res_in.quat_x = half;
            res_in.quat_y = p1; res_in.quat_z = p2;
         end
         PATH_Y: begin
            res_in.quat_w = p0; res_in.quat_x = p2;
            res_in.quat_y = half; res_in.quat_z = p1;
         end
         default: begin
            res_in.quat_w = p0; res_in.quat_x = p1;
            res_in.quat_y = p2; res_in.quat_z = half;
         end
      endcase
   end

   logic out_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (advance) out_vld_ff <= vld_ff[L];
   end
   always_ff @(posedge clock) begin
      if (advance) res_ff <= res_in;
   end

   assign out_valid = out_vld_ff;
   assign out_data  = res_ff;

   // ---------------- checks
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(out_vld_ff) && $stable(res_ff))
      else $error("pipe output moved while stalled");
   a_root_half: assert property (@(posedge clock) disable iff (reset)
      advance && vld_ff[L] |=> out_data.path_taken == $past(ctx_ff[L].path))
      else $error("path lost at output stage");
   a_recip_zero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[L] && root_ff[L] == '0 |-> quo_ff[DIV_STEPS] == '0)
      else $error("nonzero reciprocal of zero root");

endmodule

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Streaming rotation-matrix to quaternion converter, Q1.14 fixed point.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   m00..m22, nine signed 16-bit elements
//  rsp      out  quat_w/x/y/z signed 16-bit, path_taken 2-bit
//
//  one item per cycle sustained while rsp is not stalled; data passes a select
//  register, the bit-per-stage root and reciprocal chains and an output register
//  reset is synchronous and clears only the valid bits
//  when rsp is stalled the whole pipeline holds; nothing is dropped
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rmq_stream_if.sink   req,
   rmq_stream_if.source rsp
);

   logic advance;

   // pipeline moves whenever the output slot is free or being taken
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   rmq_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req.valid),
      .in_data   (req.data),
      .out_valid (rsp.valid),
      .out_data  (rsp.data)
   );

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("input taken while output stalled");

endmodule

// ===== tb/sv/rotation_matrix_to_quaternion_test.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Streams matrices through the converter with bursty input and a stalling
// output, and compares every quaternion with a fixed-point predictor.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test
   import rmq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 80;

   // quaternion scoreboard: predicts on input, checks in order on output
   class quat_scoreboard;
      quat_type pending[$];
      int       errors;
      int       checked;
      int       path_count[4];

      function automatic longint isqrt(longint v);
         longint res;
         longint bit_val;
         res = 0;
         bit_val = 64'sd1 <<< 62;
         while (bit_val > v) bit_val = bit_val >>> 2;
         while (bit_val != 0) begin
            if (v >= res + bit_val) begin
               v = v - (res + bit_val);
               res = (res >>> 1) + bit_val;
            end else begin
               res = res >>> 1;
            end
            bit_val = bit_val >>> 2;
         end
         return res;
      endfunction

      // floor(a*r / 2^14) then saturate to 16 bits
      function automatic data_type scale_sat(longint a, longint r);
         longint p;
         p = (a * r) >>> FRAC_BITS;
         if (p > 32767) p = 32767;
         if (p < -32768) p = -32768;
         return data_type'(p);
      endfunction

      function automatic data_type clip(longint v);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return data_type'(v);
      endfunction

      function automatic quat_type predict(matrix_type mat);
         longint a[3][3];
         longint trace, s, r;
         int ax, jx, kx;
         longint q[3];
         longint qw;
         quat_type res;
         a[0][0] = mat.m00; a[0][1] = mat.m01; a[0][2] = mat.m02;
         a[1][0] = mat.m10; a[1][1] = mat.m11; a[1][2] = mat.m12;
         a[2][0] = mat.m20; a[2][1] = mat.m21; a[2][2] = mat.m22;
         trace = a[0][0] + a[1][1] + a[2][2];
         if (trace > 0) begin
            s = isqrt((trace + (64'sd1 <<< FRAC_BITS)) <<< FRAC_BITS);
            r = (s == 0) ? 0 : (64'sd1 <<< (2 * FRAC_BITS - 1)) / s;
            res.quat_w = clip(s >>> 1);
            res.quat_x = scale_sat(a[2][1] - a[1][2], r);
            res.quat_y = scale_sat(a[0][2] - a[2][0], r);
            res.quat_z = scale_sat(a[1][0] - a[0][1], r);
            res.path_taken = PATH_TRACE;
         end else begin
            ax = 0;
            if (a[1][1] > a[0][0]) ax = 1;
            if (a[2][2] > a[ax][ax]) ax = 2;
            jx = (ax + 1) % 3;
            kx = (jx + 1) % 3;
            trace = a[ax][ax] - (a[jx][jx] + a[kx][kx]) + (64'sd1 <<< FRAC_BITS);
            if (trace < 0) trace = 0;
            s = isqrt(trace <<< FRAC_BITS);
            r = (s == 0) ? 0 : (64'sd1 <<< (2 * FRAC_BITS - 1)) / s;
            q[ax] = s >>> 1;
            qw = a[kx][jx] - a[jx][kx];
            q[jx] = a[jx][ax] + a[ax][jx];
            q[kx] = a[kx][ax] + a[ax][kx];
            res.quat_w = scale_sat(qw, r);
            res.quat_x = (ax == 0) ? clip(q[0]) : scale_sat(q[0], r);
            res.quat_y = (ax == 1) ? clip(q[1]) : scale_sat(q[1], r);
            res.quat_z = (ax == 2) ? clip(q[2]) : scale_sat(q[2], r);
            res.path_taken = path_type'(ax + 1);
         end
         return res;
      endfunction

      function void note_input(matrix_type mat);
         pending.push_back(predict(mat));
      endfunction

      function void check_result(quat_type got);
         quat_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected quaternion %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         path_count[want.path_taken]++;
         if (got.quat_w !== want.quat_w) begin
            $display("%0t: quat_w expected %0d actual %0d", $time, want.quat_w, got.quat_w);
            errors++;
         end
         if (got.quat_x !== want.quat_x) begin
            $display("%0t: quat_x expected %0d actual %0d", $time, want.quat_x, got.quat_x);
            errors++;
         end
         if (got.quat_y !== want.quat_y) begin
            $display("%0t: quat_y expected %0d actual %0d", $time, want.quat_y, got.quat_y);
            errors++;
         end
         if (got.quat_z !== want.quat_z) begin
            $display("%0t: quat_z expected %0d actual %0d", $time, want.quat_z, got.quat_z);
            errors++;
         end
         if (got.path_taken !== want.path_taken) begin
            $display("%0t: path_taken expected %0d actual %0d", $time,
                     want.path_taken, got.path_taken);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_cycles = 0;
   int   stall_mode = 0;

   rmq_stream_if #(.payload_type(matrix_type)) req_if ();
   rmq_stream_if #(.payload_type(quat_type))   rsp_if ();

   quat_scoreboard quat_board = new();

   rotation_matrix_to_quaternion u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   always #4 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
   end

   // output check and receiver stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) quat_board.check_result(rsp_if.data);
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic data_type rand_elem();
      case ($urandom_range(0, 5))
         0: return data_type'($urandom_range(0, 65535));
         1: return 16'sh7fff;
         2: return 16'sh8000;
         3: return data_type'(16384);
         default: return data_type'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // near-rotation: a permuted, signed axis matrix with small noise
   function automatic matrix_type rand_rotation();
      matrix_type mat;
      data_type e[9];
      int perm[3];
      int tmp, pick;
      for (int n = 0; n < 9; n++)
         e[n] = data_type'($signed($urandom_range(0, 4000)) - 2000);
      perm = '{0, 1, 2};
      for (int n = 2; n > 0; n--) begin
         pick = $urandom_range(0, n);
         tmp = perm[n]; perm[n] = perm[pick]; perm[pick] = tmp;
      end
      for (int n = 0; n < 3; n++)
         e[n * 3 + perm[n]] = $urandom_range(0, 1) ? data_type'(16384 - $urandom_range(0, 3000))
                                                   : data_type'(-16384 + $urandom_range(0, 3000));
      mat = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
      return mat;
   endfunction

   task automatic send_matrix(matrix_type mat);
      req_if.valid <= 1'b1;
      req_if.data  <= mat;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      quat_board.note_input(mat);
   endtask

   task automatic pause_sender();
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic matrix_type diag(data_type a, data_type b, data_type c);
      matrix_type mat;
      mat = '0;
      mat.m00 = a; mat.m11 = b; mat.m22 = c;
      return mat;
   endfunction

   initial begin
      matrix_type mat;
      int sent;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, axis flips, ties, zero, extremes, then six near-rotations
      send_matrix(diag(16384, 16384, 16384));
      send_matrix(diag(16384, -16384, -16384));
      send_matrix(diag(-16384, 16384, -16384));
      send_matrix(diag(-16384, -16384, 16384));
      send_matrix('0);
      send_matrix(diag(-100, -100, -100));
      send_matrix(diag(-5, 0, -5));
      send_matrix(diag(-32768, -32768, -32768));
      send_matrix(diag(32767, -32768, -32768));
      send_matrix(diag(-32768, 32767, -32768));
      send_matrix(diag(-32768, -32768, 32767));
      send_matrix('1);
      send_matrix({9{16'sh7fff}});
      send_matrix({9{16'sh8000}});
      send_matrix({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0001,
                   16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000});
      send_matrix({16'sh0001, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0000,
                   16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0000});
      send_matrix({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                   16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000});
      for (int n = 0; n < 6; n++) send_matrix(rand_rotation());

      // hold off until every quaternion has come back
      req_if.valid <= 1'b0;
      while (quat_board.pending.size() != 0) @(posedge clock);

      // random bursts: mostly near-rotations, some raw bit patterns
      sent = 0;
      while (sent < 2000) begin
         for (int b = $urandom_range(1, 40); b > 0 && sent < 2000; b--) begin
            if ($urandom_range(0, 3) == 0) begin
               mat = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                      rand_elem(), rand_elem(), rand_elem(), rand_elem()};
            end else begin
               mat = rand_rotation();
            end
            send_matrix(mat);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) pause_sender();
      end
      req_if.valid <= 1'b0;

      while (quat_board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d quaternions: trace path %0d, x %0d, y %0d, z %0d",
               quat_board.checked, quat_board.path_count[0], quat_board.path_count[1],
               quat_board.path_count[2], quat_board.path_count[3]);
      if (quat_board.errors == 0 && quat_board.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
